[rtl/csmq_pkg.sv]
// Shared types, sizes and codes for the CSMA MAC queue controller.
package csmq_pkg;

    localparam int QUEUE_DEPTH      = 16;
    localparam int HANDLE_WIDTH     = 32;
    localparam int LOSS_COUNT_WIDTH = 16;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W   = FILL_W + 1;
    localparam int LIMIT_W = 5;
    localparam int CMP_W   = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
    localparam int BACKOFF_W = 8;
    localparam int OPCODE_W  = 2;
    localparam int ACTION_W  = 3;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [LIMIT_W-1:0]   QUEUE_LIMIT_RESET  = LIMIT_W'(16);
    localparam logic [BACKOFF_W-1:0] MAX_BACKOFF_RESET  = BACKOFF_W'(5);

    // register index, taken from the word address bit
    localparam logic REG_QUEUE_LIMIT  = 1'b0;
    localparam logic REG_MAX_BACKOFFS = 1'b1;

    localparam logic [OPCODE_W-1:0] OP_UPPER_PKT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_SENSE_RSP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_TX_CONF   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_RX_IND    = 2'd3;

    localparam logic [ACTION_W-1:0] ACT_NONE    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SENSE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_XMIT    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DELIVER = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_BACKOFF = 3'd4;

    typedef struct packed {
        logic [LIMIT_W-1:0]   queue_limit;
        logic [BACKOFF_W-1:0] max_backoffs;
    } cfg_t;

    // circular pointer advance; the sum stays below twice the depth
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] a,
                                                 input logic [FILL_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [LOSS_COUNT_WIDTH-1:0] sat_inc(
        input logic [LOSS_COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + LOSS_COUNT_WIDTH'(1);
    endfunction

endpackage

[rtl/csmq_cfg.sv]
// APB configuration registers: queue limit and backoff limit.
module csmq_cfg
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csmq_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [csmq_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [csmq_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output csmq_pkg::cfg_t                      cfg
);

    logic [csmq_pkg::LIMIT_W-1:0]   queue_limit_reg;
    logic [csmq_pkg::BACKOFF_W-1:0] max_backoffs_reg;
    logic                           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_limit_reg  <= csmq_pkg::QUEUE_LIMIT_RESET;
            max_backoffs_reg <= csmq_pkg::MAX_BACKOFF_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                csmq_pkg::REG_QUEUE_LIMIT:
                begin
                    queue_limit_reg <= pwdata[csmq_pkg::LIMIT_W-1:0];
                end
                csmq_pkg::REG_MAX_BACKOFFS:
                begin
                    max_backoffs_reg <= pwdata[csmq_pkg::BACKOFF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            csmq_pkg::REG_QUEUE_LIMIT:
            begin
                prdata = csmq_pkg::APB_DATA_W'(queue_limit_reg);
            end
            csmq_pkg::REG_MAX_BACKOFFS:
            begin
                prdata = csmq_pkg::APB_DATA_W'(max_backoffs_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    assign cfg.queue_limit  = queue_limit_reg;
    assign cfg.max_backoffs = max_backoffs_reg;

endmodule

[rtl/csma_mac_queue_controller.sv]
// CSMA transmit controller top level: input register, queue update, result register.
// One event beat is taken every clock cycle unless stalled; each yields exactly one
// result beat, through the input and then the result register. The rate is set by the
// combinational update of the handle queue, head pointer, fill count and backoff state
// between the registers. Result stalls back up into the input register and then into
// in_stall. Queue entries are not cleared at reset; only entries that were written are
// ever read. Configuration writes go through an APB port (queue limit at 0x0, backoff
// limit at 0x4); the user must make them while no beat is in flight (unchecked).
module csma_mac_queue_controller
(
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      psel,
    input  logic                                      penable,
    input  logic                                      pwrite,
    input  logic [csmq_pkg::APB_ADDR_W-1:0]           paddr,
    input  logic [csmq_pkg::APB_DATA_W-1:0]           pwdata,
    output logic [csmq_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                      pready,

    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [csmq_pkg::OPCODE_W-1:0]             opcode,
    input  logic [csmq_pkg::HANDLE_WIDTH-1:0]         payload,
    input  logic                                      channel_busy,

    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [csmq_pkg::ACTION_W-1:0]             action,
    output logic [csmq_pkg::HANDLE_WIDTH-1:0]         payload_out,
    output logic                                      overflow_drop,
    output logic                                      backoff_drop,
    output logic [csmq_pkg::FILL_W-1:0]               queue_count,
    output logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0]     overflow_losses,
    output logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0]     backoff_losses
);

    csmq_pkg::cfg_t cfg;

    csmq_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register
    logic                                  in_valid_reg;
    logic [csmq_pkg::OPCODE_W-1:0]         op_reg;
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     pay_reg;
    logic                                  busy_reg;

    // controller state
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     queue_mem [csmq_pkg::QUEUE_DEPTH];
    logic [csmq_pkg::PTR_W-1:0]            head_reg, head_next;
    logic [csmq_pkg::FILL_W-1:0]           fill_reg, fill_next;
    logic [csmq_pkg::BACKOFF_W-1:0]        tries_reg, tries_next;
    logic                                  pend_reg, pend_next;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] ocnt_reg, ocnt_next;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] bcnt_reg, bcnt_next;

    // result register
    logic                                  out_valid_reg;
    logic [csmq_pkg::ACTION_W-1:0]         action_reg, action_next;
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     pout_reg, pout_next;
    logic                                  odrop_reg, odrop_next;
    logic                                  bdrop_reg, bdrop_next;

    logic                                  advance;
    logic                                  in_take;
    logic                                  wr_en;
    logic [csmq_pkg::PTR_W-1:0]            wr_idx;
    logic [csmq_pkg::CMP_W-1:0]            limit_eff;
    logic                                  queue_full;
    logic [csmq_pkg::BACKOFF_W-1:0]        tries_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign limit_eff = (csmq_pkg::CMP_W'(cfg.queue_limit) >
                        csmq_pkg::CMP_W'(csmq_pkg::QUEUE_DEPTH)) ?
                       csmq_pkg::CMP_W'(csmq_pkg::QUEUE_DEPTH) :
                       csmq_pkg::CMP_W'(cfg.queue_limit);
    assign queue_full = csmq_pkg::CMP_W'(fill_reg) >= limit_eff;
    assign wr_idx     = csmq_pkg::ptr_add(head_reg, fill_reg);
    assign tries_inc  = tries_reg + csmq_pkg::BACKOFF_W'(1);

    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        tries_next  = tries_reg;
        pend_next   = pend_reg;
        ocnt_next   = ocnt_reg;
        bcnt_next   = bcnt_reg;
        action_next = csmq_pkg::ACT_NONE;
        pout_next   = '0;
        odrop_next  = 1'b0;
        bdrop_next  = 1'b0;
        wr_en       = 1'b0;

        unique case (op_reg)
            csmq_pkg::OP_UPPER_PKT:
            begin
                if (queue_full)
                begin
                    odrop_next = 1'b1;
                    ocnt_next  = csmq_pkg::sat_inc(ocnt_reg);
                end
                else
                begin
                    wr_en     = 1'b1;
                    fill_next = fill_reg + csmq_pkg::FILL_W'(1);
                end
                // request carrier sense on the updated fill
                if (!pend_reg && (fill_next != '0))
                begin
                    pend_next   = 1'b1;
                    action_next = csmq_pkg::ACT_SENSE;
                end
            end
            csmq_pkg::OP_SENSE_RSP:
            begin
                if (!pend_reg)
                begin
                    // timer expiry: only re-check
                    if (fill_reg != '0)
                    begin
                        pend_next   = 1'b1;
                        action_next = csmq_pkg::ACT_SENSE;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (fill_reg != '0)
                    begin
                        if (!busy_reg)
                        begin
                            tries_next  = '0;
                            pout_next   = queue_mem[head_reg];
                            head_next   = csmq_pkg::ptr_add(head_reg, csmq_pkg::FILL_W'(1));
                            fill_next   = fill_reg - csmq_pkg::FILL_W'(1);
                            action_next = csmq_pkg::ACT_XMIT;
                        end
                        else if (tries_inc < cfg.max_backoffs)
                        begin
                            tries_next  = tries_inc;
                            action_next = csmq_pkg::ACT_BACKOFF;
                        end
                        else
                        begin
                            // give up on the head packet
                            tries_next = '0;
                            head_next  = csmq_pkg::ptr_add(head_reg, csmq_pkg::FILL_W'(1));
                            fill_next  = fill_reg - csmq_pkg::FILL_W'(1);
                            bdrop_next = 1'b1;
                            bcnt_next  = csmq_pkg::sat_inc(bcnt_reg);
                        end
                    end
                end
            end
            csmq_pkg::OP_TX_CONF:
            begin
                if (!pend_reg && (fill_reg != '0))
                begin
                    pend_next   = 1'b1;
                    action_next = csmq_pkg::ACT_SENSE;
                end
            end
            csmq_pkg::OP_RX_IND:
            begin
                action_next = csmq_pkg::ACT_DELIVER;
                pout_next   = pay_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            fill_reg      <= '0;
            tries_reg     <= '0;
            pend_reg      <= 1'b0;
            ocnt_reg      <= '0;
            bcnt_reg      <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                head_reg      <= head_next;
                fill_reg      <= fill_next;
                tries_reg     <= tries_next;
                pend_reg      <= pend_next;
                ocnt_reg      <= ocnt_next;
                bcnt_reg      <= bcnt_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg   <= opcode;
            pay_reg  <= payload;
            busy_reg <= channel_busy;
        end
        if (advance)
        begin
            action_reg <= action_next;
            pout_reg   <= pout_next;
            odrop_reg  <= odrop_next;
            bdrop_reg  <= bdrop_next;
            if (wr_en)
            begin
                queue_mem[wr_idx] <= pay_reg;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = action_reg;
    assign payload_out     = pout_reg;
    assign overflow_drop   = odrop_reg;
    assign backoff_drop    = bdrop_reg;
    assign queue_count     = fill_reg;
    assign overflow_losses = ocnt_reg;
    assign backoff_losses  = bcnt_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= csmq_pkg::FILL_W'(csmq_pkg::QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (fill_reg != '0))
        else $error("sense pending with empty queue");

    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed beat produced no result");

    a_rx_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (op_reg == csmq_pkg::OP_RX_IND)) |=>
        ((action_reg == csmq_pkg::ACT_DELIVER) && (fill_reg == $past(fill_reg))))
        else $error("receive indication mishandled");

    a_xmit_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (action_reg == csmq_pkg::ACT_XMIT)) |-> (!odrop_reg && !bdrop_reg))
        else $error("transmit request with a drop flag");

endmodule

[test/testbench.sv]
// Testbench for the CSMA MAC queue controller: random event beats, APB setup, scoreboard.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [csmq_pkg::OPCODE_W-1:0]     op;
        logic [csmq_pkg::HANDLE_WIDTH-1:0] handle;
        logic                              busy;
    } mac_event_t;

    typedef struct packed {
        logic [csmq_pkg::ACTION_W-1:0]         action;
        logic [csmq_pkg::HANDLE_WIDTH-1:0]     handle;
        logic                                  ovf_drop;
        logic                                  bko_drop;
        logic [csmq_pkg::FILL_W-1:0]           fill;
        logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] ovf_losses;
        logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] bko_losses;
    } mac_result_t;

    logic                                  clk           = 1'b0;
    logic                                  rst_n         = 1'b0;
    logic                                  psel          = 1'b0;
    logic                                  penable       = 1'b0;
    logic                                  pwrite        = 1'b0;
    logic [csmq_pkg::APB_ADDR_W-1:0]       paddr         = '0;
    logic [csmq_pkg::APB_DATA_W-1:0]       pwdata        = '0;
    logic [csmq_pkg::APB_DATA_W-1:0]       prdata;
    logic                                  pready;
    logic                                  in_valid      = 1'b0;
    logic                                  in_stall;
    logic [csmq_pkg::OPCODE_W-1:0]         opcode        = '0;
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     payload       = '0;
    logic                                  channel_busy  = 1'b0;
    logic                                  out_valid;
    logic                                  out_stall     = 1'b0;
    logic [csmq_pkg::ACTION_W-1:0]         action;
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     payload_out;
    logic                                  overflow_drop;
    logic                                  backoff_drop;
    logic [csmq_pkg::FILL_W-1:0]           queue_count;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] overflow_losses;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] backoff_losses;

    // mirror of the controller state
    logic [csmq_pkg::HANDLE_WIDTH-1:0]     handle_ring [csmq_pkg::QUEUE_DEPTH];
    logic [csmq_pkg::PTR_W-1:0]            ring_head;
    logic [csmq_pkg::FILL_W-1:0]           ring_fill;
    logic [csmq_pkg::BACKOFF_W-1:0]        busy_tries;
    logic                                  sense_wait;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] ovf_count;
    logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] bko_count;
    logic [csmq_pkg::LIMIT_W-1:0]          cfg_limit;
    logic [csmq_pkg::BACKOFF_W-1:0]        cfg_max_backoffs;

    mac_event_t  pending_events [$];
    mac_result_t awaited_results [$];
    int          events_sent  = 0;
    int          events_taken = 0;
    int          miss_count   = 0;
    bit          in_taken     = 1'b0;
    bit          quiet        = 1'b0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          hold_left    = 0;
    bit          long_hold_done = 1'b0;

    csma_mac_queue_controller u_dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .opcode          (opcode),
        .payload         (payload),
        .channel_busy    (channel_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .action          (action),
        .payload_out     (payload_out),
        .overflow_drop   (overflow_drop),
        .backoff_drop    (backoff_drop),
        .queue_count     (queue_count),
        .overflow_losses (overflow_losses),
        .backoff_losses  (backoff_losses)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] saturate_up(
        input logic [csmq_pkg::LOSS_COUNT_WIDTH-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [csmq_pkg::ACTION_W-1:0] sense_if_needed();
        if (ring_fill == 0 || sense_wait)
        begin
            return csmq_pkg::ACT_NONE;
        end
        sense_wait = 1'b1;
        return csmq_pkg::ACT_SENSE;
    endfunction

    function automatic mac_result_t mac_step(input mac_event_t ev);
        mac_result_t r;
        int          lim;
        int          slot;
        r   = '0;
        lim = (int'(cfg_limit) > csmq_pkg::QUEUE_DEPTH) ? csmq_pkg::QUEUE_DEPTH :
              int'(cfg_limit);
        case (ev.op)
            csmq_pkg::OP_UPPER_PKT:
            begin
                if (int'(ring_fill) >= lim)
                begin
                    r.ovf_drop = 1'b1;
                    ovf_count  = saturate_up(ovf_count);
                end
                else
                begin
                    slot = (int'(ring_head) + int'(ring_fill)) % csmq_pkg::QUEUE_DEPTH;
                    handle_ring[slot] = ev.handle;
                    ring_fill = ring_fill + 1'b1;
                end
                r.action = sense_if_needed();
            end
            csmq_pkg::OP_SENSE_RSP:
            begin
                // no request outstanding: the backoff timer fired
                if (!sense_wait)
                begin
                    r.action = sense_if_needed();
                end
                else
                begin
                    sense_wait = 1'b0;
                    if (ring_fill != 0)
                    begin
                        if (!ev.busy)
                        begin
                            busy_tries = '0;
                            r.handle   = handle_ring[ring_head];
                            r.action   = csmq_pkg::ACT_XMIT;
                            ring_head  = csmq_pkg::PTR_W'((int'(ring_head) + 1) %
                                                          csmq_pkg::QUEUE_DEPTH);
                            ring_fill  = ring_fill - 1'b1;
                        end
                        else
                        begin
                            busy_tries = busy_tries + 1'b1;
                            if (busy_tries < cfg_max_backoffs)
                            begin
                                r.action = csmq_pkg::ACT_BACKOFF;
                            end
                            else
                            begin
                                busy_tries = '0;
                                ring_head  = csmq_pkg::PTR_W'((int'(ring_head) + 1) %
                                                              csmq_pkg::QUEUE_DEPTH);
                                ring_fill  = ring_fill - 1'b1;
                                r.bko_drop = 1'b1;
                                bko_count  = saturate_up(bko_count);
                            end
                        end
                    end
                end
            end
            csmq_pkg::OP_TX_CONF:
            begin
                r.action = sense_if_needed();
            end
            default:
            begin
                r.action = csmq_pkg::ACT_DELIVER;
                r.handle = ev.handle;
            end
        endcase
        r.fill       = ring_fill;
        r.ovf_losses = ovf_count;
        r.bko_losses = bko_count;
        return r;
    endfunction

    task automatic log_miss(input string what, input mac_result_t want,
                            input mac_result_t got);
        miss_count++;
        if (miss_count <= 10)
        begin
            $display("[%0t] %s: exp act=%0d h=%h od=%b bd=%b n=%0d ol=%0d bl=%0d",
                     $time, what, want.action, want.handle, want.ovf_drop, want.bko_drop,
                     want.fill, want.ovf_losses, want.bko_losses);
            $display("           got act=%0d h=%h od=%b bd=%b n=%0d ol=%0d bl=%0d",
                     got.action, got.handle, got.ovf_drop, got.bko_drop,
                     got.fill, got.ovf_losses, got.bko_losses);
        end
    endtask

    // driver: present the next event beat, hold it until taken
    always @(negedge clk)
    begin : drive_events
        mac_event_t ev;
        if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_events.size() == 0)
            begin
                in_valid <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                in_valid <= 1'b0;
                gap_left <= $urandom_range(0, 9);
            end
            else
            begin
                ev = pending_events[0];
                pending_events.delete(0);
                in_valid     <= 1'b1;
                opcode       <= ev.op;
                payload      <= ev.handle;
                channel_busy <= ev.busy;
            end
        end
    end

    // result side back-pressure, with one long hold to fill the pipeline
    always @(negedge clk)
    begin : drive_stall
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && events_taken >= 150)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= 59;
            out_stall      <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 9);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: score result beats, predict each accepted event beat
    always @(posedge clk)
    begin : watch_beats
        mac_result_t want;
        mac_result_t got;
        mac_event_t  seen;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{action, payload_out, overflow_drop, backoff_drop, queue_count,
                        overflow_losses, backoff_losses};
                if (awaited_results.size() == 0)
                begin
                    log_miss("result with none awaited", '0, got);
                end
                else
                begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (got !== want)
                    begin
                        log_miss("result mismatch", want, got);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                seen = '{opcode, payload, channel_busy};
                awaited_results.insert(awaited_results.size(), mac_step(seen));
                events_taken++;
            end
        end
    end

    task automatic post(input logic [csmq_pkg::OPCODE_W-1:0] op,
                        input logic [csmq_pkg::HANDLE_WIDTH-1:0] h,
                        input logic b);
        mac_event_t ev;
        ev = '{op, h, b};
        pending_events.insert(pending_events.size(), ev);
        events_sent++;
    endtask

    task automatic wait_drained();
        while (!(events_taken == events_sent && awaited_results.size() == 0))
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic reg_write(input logic reg_idx,
                             input logic [csmq_pkg::APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= csmq_pkg::APB_ADDR_W'({reg_idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!pready);
        if (reg_idx == csmq_pkg::REG_QUEUE_LIMIT)
        begin
            cfg_limit = value[csmq_pkg::LIMIT_W-1:0];
        end
        else
        begin
            cfg_max_backoffs = value[csmq_pkg::BACKOFF_W-1:0];
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input int limit, input int max_tries);
        wait_drained();
        reg_write(csmq_pkg::REG_QUEUE_LIMIT, limit);
        reg_write(csmq_pkg::REG_MAX_BACKOFFS, max_tries);
    endtask

    task automatic queue_random(input int beats, input int w_arrive, input int w_sense,
                                input int w_conf, input int w_rx, input int busy_pct);
        logic [csmq_pkg::OPCODE_W-1:0]     op;
        logic [csmq_pkg::HANDLE_WIDTH-1:0] h;
        logic                              b;
        int                                pick;
        repeat (beats)
        begin
            pick = $urandom_range(0, w_arrive + w_sense + w_conf + w_rx - 1);
            if (pick < w_arrive)
                op = csmq_pkg::OP_UPPER_PKT;
            else if (pick < w_arrive + w_sense)
                op = csmq_pkg::OP_SENSE_RSP;
            else if (pick < w_arrive + w_sense + w_conf)
                op = csmq_pkg::OP_TX_CONF;
            else
                op = csmq_pkg::OP_RX_IND;
            case ($urandom_range(0, 15))
                0:       h = '0;
                1:       h = '1;
                default: h = $urandom;
            endcase
            if (op == csmq_pkg::OP_SENSE_RSP)
                b = ($urandom_range(0, 99) < busy_pct);
            else
                b = $urandom_range(0, 1);
            post(op, h, b);
        end
    endtask

    initial
    begin : stimulus
        ring_head        = '0;
        ring_fill        = '0;
        busy_tries       = '0;
        sense_wait       = 1'b0;
        ovf_count        = '0;
        bko_count        = '0;
        cfg_limit        = csmq_pkg::QUEUE_LIMIT_RESET;
        cfg_max_backoffs = csmq_pkg::MAX_BACKOFF_RESET;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: idle events, delivery extremes, busy then free channel
        post(csmq_pkg::OP_TX_CONF,   32'h0000_0000, 1'b0);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b0);
        post(csmq_pkg::OP_RX_IND,    32'h0000_0000, 1'b0);
        post(csmq_pkg::OP_RX_IND,    32'hFFFF_FFFF, 1'b1);
        post(csmq_pkg::OP_UPPER_PKT, 32'hFFFF_FFFF, 1'b1);
        post(csmq_pkg::OP_UPPER_PKT, 32'h0000_0000, 1'b0);
        post(csmq_pkg::OP_SENSE_RSP, 32'h1234_5678, 1'b1);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b1);
        post(csmq_pkg::OP_SENSE_RSP, 32'hFFFF_FFFF, 1'b0);
        post(csmq_pkg::OP_TX_CONF,   32'hFFFF_FFFF, 1'b1);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b0);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b1);

        // single entry; a try limit of one drops the head on the first busy
        configure(1, 1);
        post(csmq_pkg::OP_UPPER_PKT, 32'hA5A5_A5A5, 1'b0);
        post(csmq_pkg::OP_UPPER_PKT, 32'h5A5A_5A5A, 1'b0);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b1);
        post(csmq_pkg::OP_UPPER_PKT, 32'h0000_0001, 1'b0);

        // zero limit refuses every arrival; zero tries drops on first busy
        configure(0, 0);
        post(csmq_pkg::OP_UPPER_PKT, 32'h8000_0000, 1'b1);
        post(csmq_pkg::OP_SENSE_RSP, 32'h0000_0000, 1'b1);
        post(csmq_pkg::OP_UPPER_PKT, 32'h7FFF_FFFF, 1'b0);
        post(csmq_pkg::OP_TX_CONF,   32'h0000_0000, 1'b0);

        configure(16, 5);
        queue_random(300, 35, 35, 15, 15, 50);

        // limit above depth, arrival heavy: fill to the brim and overflow
        configure(31, 3);
        quiet = 1'b1;
        queue_random(250, 60, 25, 10, 5, 40);
        quiet = 1'b0;

        // lowered limit keeps the backlog; always busy walks toward the try limit
        configure(2, 255);
        queue_random(480, 3, 90, 5, 2, 100);

        configure(1, 1);
        queue_random(200, 35, 35, 15, 15, 50);
        configure(0, 0);
        queue_random(120, 40, 35, 15, 10, 50);
        configure(9, 128);
        queue_random(200, 40, 40, 10, 10, 30);
        configure(16, 5);
        queue_random(200, 35, 35, 15, 15, 60);

        // closing stretch at full rate
        configure(4, 2);
        quiet = 1'b1;
        queue_random(80, 40, 40, 10, 10, 50);

        wait_drained();
        repeat (8) @(posedge clk);
        if (miss_count == 0 && awaited_results.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin : watchdog
        #1_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[sim.f]
rtl/csmq_pkg.sv
rtl/csmq_cfg.sv
rtl/csma_mac_queue_controller.sv
test/testbench.sv
